// ===== hdl/glsig_pkg.sv =====
// Shared types and constants for the grid LOD seam index generator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package glsig_pkg;

   localparam int unsigned MAX_SIDE = 64;
   localparam int unsigned SIDE_W   = 7;
   localparam int unsigned IDX_W    = 13;

   localparam logic [2:0] PART_CELL   = 3'd0;
   localparam logic [2:0] PART_LEFT   = 3'd1;
   localparam logic [2:0] PART_RIGHT  = 3'd2;
   localparam logic [2:0] PART_BOTTOM = 3'd3;
   localparam logic [2:0] PART_TOP    = 3'd4;

   localparam int SEAM_L = 0;
   localparam int SEAM_B = 1;
   localparam int SEAM_R = 2;
   localparam int SEAM_T = 3;

   localparam logic CSR_CHUNK_WIDTH  = 1'b0;
   localparam logic CSR_CHUNK_HEIGHT = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [2:0] {
      KIND_CELL,
      KIND_LEFT,
      KIND_RIGHT,
      KIND_BOTTOM,
      KIND_TOP
   } kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic              parity;
      logic [2:0]        mask;
      logic [SIDE_W-1:0] x;
      logic [SIDE_W-1:0] y;
   } place_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     parity;
      logic [2:0] mask;
      idx_type  base;
   } base_type;

   typedef struct packed {
      idx_type a;
      idx_type b;
      idx_type c;
   } tri_type;

   typedef struct packed {
      logic          valid;
      logic [2:0]    mask;
      tri_type [2:0] tris;
   } batch_type;

endpackage

`default_nettype wire

// ===== hdl/grid_lod_seam_index_generator.sv =====
// Top level of the grid LOD seam index generator.
// Depends on glsig_pkg, glsig_decode, glsig_addr and glsig_serial.
//
// Usage:
//   Request: drive req_* and raise start; the beat is taken at an edge where
//   busy is low. Parts: interior cell, or a left/right/bottom/top seam segment.
//   Response: each triangle is one beat on rsp_index_a/b/c with rsp_valid high
//   for one cycle; rsp_last marks the final triangle of a request. Requests
//   that give no triangle produce no beat at all.
//   Config: csr_we with csr_index and csr_wdata sets chunk width or height;
//   write only while no request is in flight.
//   Path: the first triangle passes the decode, base multiply, corner,
//   serializer and output registers after the accepting edge.
//   Throughput: one request per cycle while each yields at most one triangle;
//   requests with two or three triangles hold the serializer until one is left,
//   and busy stalls decode and address until it can take the next batch.
//   Reset: empties the pipe and loads width and height of 16.
//   The receiver cannot stall: pending beats leave one per cycle unconditionally.
`default_nettype none

module grid_lod_seam_index_generator import glsig_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_seam_mask,
   input  logic [2:0]        req_part,
   input  logic [5:0]        req_col,
   input  logic [5:0]        req_row,
   output logic              rsp_valid,
   output idx_type           rsp_index_a,
   output idx_type           rsp_index_b,
   output idx_type           rsp_index_c,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [SIDE_W-1:0] csr_wdata
);

   logic [SIDE_W-1:0] width_ff;
   logic [SIDE_W-1:0] height_ff;
   logic              hold;
   logic              take;
   logic              ready;
   place_type         place;
   batch_type         batch;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd16;
         height_ff <= 7'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHUNK_WIDTH:  width_ff  <= csr_wdata;
            CSR_CHUNK_HEIGHT: height_ff <= csr_wdata;
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   assign hold = batch.valid && (batch.mask != 3'b000) && !ready;
   assign take = start && !hold;
   assign busy = hold;

   glsig_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .hold          (hold),
      .take          (take),
      .req_seam_mask (req_seam_mask),
      .req_part      (req_part),
      .req_col       (req_col),
      .req_row       (req_row),
      .chunk_width   (width_ff),
      .chunk_height  (height_ff),
      .place         (place)
   );

   glsig_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .hold        (hold),
      .place       (place),
      .chunk_width (width_ff),
      .batch       (batch)
   );

   glsig_serial u_serial (
      .clock       (clock),
      .reset       (reset),
      .batch       (batch),
      .ready       (ready),
      .rsp_valid   (rsp_valid),
      .rsp_index_a (rsp_index_a),
      .rsp_index_b (rsp_index_b),
      .rsp_index_c (rsp_index_c),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hdl/glsig_decode.sv =====
// Input register and part decode: range checks, seam cuts, grid corner.
// Depends on glsig_pkg.
`default_nettype none

module glsig_decode import glsig_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   input  logic              take,
   input  logic [3:0]        req_seam_mask,
   input  logic [2:0]        req_part,
   input  logic [5:0]        req_col,
   input  logic [5:0]        req_row,
   input  logic [SIDE_W-1:0] chunk_width,
   input  logic [SIDE_W-1:0] chunk_height,
   output place_type         place
);

   logic       s1_valid_ff;
   logic [3:0] s1_seam_ff;
   logic [2:0] s1_part_ff;
   logic [5:0] s1_col_ff;
   logic [5:0] s1_row_ff;
   place_type  place_ff;
   place_type  place_in;

   logic              size_ok;
   logic              in_cell;
   logic              seg_ok;
   logic              first_cut;
   logic              last_cut;
   logic [5:0]        half_w;
   logic [5:0]        half_h;
   logic [SIDE_W-1:0] x_hi;
   logic [SIDE_W-1:0] y_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         place_ff    <= '0;
      end else if (!hold) begin
         s1_valid_ff <= take;
         place_ff    <= place_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !hold) begin
         s1_seam_ff <= req_seam_mask;
         s1_part_ff <= req_part;
         s1_col_ff  <= req_col;
         s1_row_ff  <= req_row;
      end
   end

   always_comb begin
      half_w  = chunk_width[SIDE_W-1:1];
      half_h  = chunk_height[SIDE_W-1:1];
      size_ok = !chunk_width[0] && !chunk_height[0]
                && (chunk_width >= 7'd2) && (chunk_height >= 7'd2)
                && (32'(chunk_width) <= MAX_SIDE) && (32'(chunk_height) <= MAX_SIDE);
      x_hi = s1_seam_ff[SEAM_R] ? chunk_width - 7'd1 : chunk_width;
      y_hi = s1_seam_ff[SEAM_T] ? chunk_height - 7'd1 : chunk_height;
      in_cell = ({1'b0, s1_col_ff} >= {6'd0, s1_seam_ff[SEAM_L]})
                && ({1'b0, s1_col_ff} < x_hi)
                && ({1'b0, s1_row_ff} >= {6'd0, s1_seam_ff[SEAM_B]})
                && ({1'b0, s1_row_ff} < y_hi);
      seg_ok    = 1'b0;
      first_cut = 1'b0;
      last_cut  = 1'b0;

      place_in.valid  = s1_valid_ff;
      place_in.kind   = KIND_CELL;
      place_in.parity = s1_col_ff[0] ^ s1_row_ff[0];
      place_in.mask   = 3'b000;
      place_in.x      = '0;
      place_in.y      = '0;

      unique case (s1_part_ff) inside
         PART_CELL: begin
            place_in.kind = KIND_CELL;
            place_in.x    = {1'b0, s1_col_ff};
            place_in.y    = {1'b0, s1_row_ff};
            place_in.mask = in_cell ? 3'b011 : 3'b000;
         end
         PART_LEFT, PART_RIGHT: begin
            seg_ok    = ((s1_part_ff == PART_LEFT) ? s1_seam_ff[SEAM_L] : s1_seam_ff[SEAM_R])
                        && (s1_row_ff < half_h);
            first_cut = (s1_row_ff == 6'd0) && s1_seam_ff[SEAM_B];
            last_cut  = (s1_row_ff == half_h - 6'd1) && s1_seam_ff[SEAM_T];
            place_in.kind = (s1_part_ff == PART_LEFT) ? KIND_LEFT : KIND_RIGHT;
            place_in.x    = (s1_part_ff == PART_LEFT) ? '0 : chunk_width - 7'd1;
            place_in.y    = {s1_row_ff, 1'b0};
            place_in.mask = seg_ok ? {!last_cut, !first_cut, 1'b1} : 3'b000;
         end
         PART_BOTTOM, PART_TOP: begin
            seg_ok    = ((s1_part_ff == PART_BOTTOM) ? s1_seam_ff[SEAM_B] : s1_seam_ff[SEAM_T])
                        && (s1_col_ff < half_w);
            first_cut = (s1_col_ff == 6'd0) && s1_seam_ff[SEAM_L];
            last_cut  = (s1_col_ff == half_w - 6'd1) && s1_seam_ff[SEAM_R];
            place_in.kind = (s1_part_ff == PART_BOTTOM) ? KIND_BOTTOM : KIND_TOP;
            place_in.x    = {s1_col_ff, 1'b0};
            place_in.y    = (s1_part_ff == PART_BOTTOM) ? '0 : chunk_height - 7'd1;
            place_in.mask = seg_ok ? {!last_cut, !first_cut, 1'b1} : 3'b000;
         end
         default: begin
            place_in.mask = 3'b000;
         end
      endcase

      if (!size_ok || !s1_valid_ff) begin
         place_in.mask = 3'b000;
      end
   end

   assign place = place_ff;

endmodule

`default_nettype wire

// ===== hdl/glsig_addr.sv =====
// Base vertex multiply stage and triangle corner stage.
// Depends on glsig_pkg.
`default_nettype none

module glsig_addr import glsig_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   input  place_type         place,
   input  logic [SIDE_W-1:0] chunk_width,
   output batch_type         batch
);

   logic [SIDE_W:0]          stride;
   logic [IDX_W-1:0]         prod;
   base_type                 base_ff;
   base_type                 base_in;
   batch_type                batch_ff;
   batch_type                batch_in;
   idx_type st;
   idx_type b;
   idx_type o1;
   idx_type o2;
   idx_type os;
   idx_type os1;
   idx_type os2;
   idx_type o2s;
   idx_type o2s1;

   function automatic tri_type mk_tri(idx_type a, idx_type bb, idx_type c);
      tri_type t;
      t.a = a;
      t.b = bb;
      t.c = c;
      return t;
   endfunction

   always_comb begin
      stride         = {1'b0, chunk_width} + 8'd1;
      prod           = IDX_W'(place.y) * IDX_W'(stride);
      base_in.valid  = place.valid;
      base_in.kind   = place.kind;
      base_in.parity = place.parity;
      base_in.mask   = place.mask;
      base_in.base   = IDX_W'(place.x) + prod;
   end

   always_comb begin
      st   = IDX_W'(stride);
      b    = base_ff.base;
      o1   = b + 13'd1;
      o2   = b + 13'd2;
      os   = b + st;
      os1  = os + 13'd1;
      os2  = os + 13'd2;
      o2s  = os + st;
      o2s1 = o2s + 13'd1;

      batch_in.valid = base_ff.valid;
      batch_in.mask  = base_ff.mask;
      unique case (base_ff.kind)
         KIND_CELL: begin
            if (base_ff.parity) begin
               batch_in.tris[0] = mk_tri(b, o1, os);
               batch_in.tris[1] = mk_tri(o1, os1, os);
            end else begin
               batch_in.tris[0] = mk_tri(b, os1, os);
               batch_in.tris[1] = mk_tri(b, o1, os1);
            end
            batch_in.tris[2] = batch_in.tris[1];
         end
         KIND_LEFT: begin
            batch_in.tris[0] = mk_tri(b, os1, o2s);
            batch_in.tris[1] = mk_tri(b, o1, os1);
            batch_in.tris[2] = mk_tri(os1, o2s1, o2s);
         end
         KIND_RIGHT: begin
            batch_in.tris[0] = mk_tri(o1, o2s1, os);
            batch_in.tris[1] = mk_tri(b, o1, os);
            batch_in.tris[2] = mk_tri(os, o2s1, o2s);
         end
         KIND_BOTTOM: begin
            batch_in.tris[0] = mk_tri(b, o2, os1);
            batch_in.tris[1] = mk_tri(b, os1, os);
            batch_in.tris[2] = mk_tri(o2, os2, os1);
         end
         KIND_TOP: begin
            batch_in.tris[0] = mk_tri(os, o1, os2);
            batch_in.tris[1] = mk_tri(b, o1, os);
            batch_in.tris[2] = mk_tri(o1, o2, os2);
         end
         default: begin
            batch_in.mask = 3'b000;
            batch_in.tris = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         batch_ff <= '0;
      end else if (!hold) begin
         base_ff  <= base_in;
         batch_ff <= batch_in;
      end
   end

   assign batch = batch_ff;

endmodule

`default_nettype wire

// ===== hdl/glsig_serial.sv =====
// Triangle serializer: holds up to three triangles, sends one beat per cycle.
// Depends on glsig_pkg.
`default_nettype none

module glsig_serial import glsig_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  batch_type batch,
   output logic      ready,
   output logic      rsp_valid,
   output idx_type   rsp_index_a,
   output idx_type   rsp_index_b,
   output idx_type   rsp_index_c,
   output logic      rsp_last
);

   logic [2:0]    mask_ff;
   logic [2:0]    mask_in;
   logic [2:0]    pick;
   logic [2:0]    rest;
   logic          load;
   tri_type [2:0] tris_ff;
   tri_type [2:0] tris_in;
   tri_type       pick_tri;
   logic          rsp_valid_ff;
   logic          rsp_last_ff;
   tri_type       rsp_tri_ff;

   always_comb begin
      pick    = mask_ff & (~mask_ff + 3'd1);
      rest    = mask_ff & ~pick;
      ready   = (rest == 3'b000);
      load    = batch.valid && (batch.mask != 3'b000) && ready;
      mask_in = load ? batch.mask : rest;
      tris_in = load ? batch.tris : tris_ff;
      case (pick)
         3'b010:  pick_tri = tris_ff[1];
         3'b100:  pick_tri = tris_ff[2];
         default: pick_tri = tris_ff[0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= 3'b000;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= (mask_ff != 3'b000);
         rsp_last_ff  <= (mask_ff != 3'b000) && (rest == 3'b000);
      end
   end

   always_ff @(posedge clock) begin
      tris_ff    <= tris_in;
      rsp_tri_ff <= pick_tri;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_index_a = rsp_tri_ff.a;
   assign rsp_index_b = rsp_tri_ff.b;
   assign rsp_index_c = rsp_tri_ff.c;

   a_load_near_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> ($countones(mask_ff) <= 1))
      else $error("batch loaded over pending triangles");

   a_pending_sends: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != 3'b000) |=> rsp_valid_ff)
      else $error("pending triangle not sent");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (mask_ff != 3'b000))
      else $error("beat without last but nothing pending");

   a_last_in_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_valid_ff)
      else $error("last flag outside a beat");

endmodule

`default_nettype wire
